// File: src/rplm_pkg.sv
// Package for the refcounted page location map.
// Holds field widths, location codes, count limit and the mode type.
// No dependencies.
`default_nettype none

package rplm_pkg;

	localparam int ENTRIES_DEF  = 4096;
	localparam int SPP_DEF      = 8;

	localparam int SECTOR_W     = 15;
	localparam int IDX_W        = 12;
	localparam int PAGE_W       = 12;
	localparam int LOC_W        = 13;
	localparam int CNT_W        = 13;
	localparam int MODE_W       = 2;
	localparam int IN_DATA_W    = 40;
	localparam int OUT_DATA_W   = 40;

	localparam int PAGE_SPACE   = 4096;
	localparam int MAP_LIMIT    = 32768;

	localparam logic [LOC_W-1:0] LOC_UNWRITTEN = 13'h1FFF;
	localparam logic [LOC_W-1:0] LOC_IN_BUF    = 13'h1FFE;
	localparam logic [CNT_W-1:0] COUNT_MAX     = 13'd4096;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE = 2'd0,
		MODE_FLUSH = 2'd1,
		MODE_ALLOC = 2'd2,
		MODE_QUERY = 2'd3
	} mode_t;

endpackage

`default_nettype wire

// File: src/rplm_div.sv
// Division of a sector address by a constant divisor through a reciprocal multiply.
// The quotient is registered and shows in the cycle after start; depends on rplm_pkg.
`default_nettype none

module rplm_div #(
	parameter int DIVISOR = rplm_pkg::SPP_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [rplm_pkg::SECTOR_W-1:0] dividend,
	output logic                               done,
	output logic [rplm_pkg::SECTOR_W-1:0]      quotient
);

	localparam int W     = rplm_pkg::SECTOR_W;
	localparam int SHIFT = W + $clog2(DIVISOR);
	localparam int RW    = W + 2;
	localparam int PRW   = W + RW;
	localparam logic [RW-1:0] RECIP = RW'(((1 << SHIFT) + DIVISOR - 1) / DIVISOR);

	logic            done_q;
	logic [W-1:0]    quo_q;
	logic [PRW-1:0]  prod;

	assign prod = PRW'(dividend) * PRW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			quo_q  <= '0;
		end else begin
			done_q <= start;
			if (start) begin
				quo_q <= W'(prod >> SHIFT);
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: src/refcounted_page_location_map_top.sv
// Top level of the refcounted page location map: location and count memories,
// sequencer and output register. Depends on rplm_pkg and rplm_div.
//
//   channel  direction  tdata (lowest bit up)                          tuser
//   s_*      in         sector_address, entry_index, target_page       mode
//   m_*      out        location, ref_count, free_page, found          -
//
// After reset a clearing pass marks all min(ENTRIES, 32768) map entries unwritten and zeroes
// the counts; no item is taken meanwhile. Flush and query pass the read and execute states, while
// a sector write first waits for the divider and, if the entry held a page, passes a decrement state.
// Allocate checks the hint first and, if it is good, needs no scan; otherwise it scans the count
// memory at one page per cycle through its single read port, over at most min(ENTRIES, 4096) pages.
// One item is in work at a time; a result waits in the output register until taken.
`default_nettype none

module refcounted_page_location_map_top #(
	parameter int ENTRIES            = rplm_pkg::ENTRIES_DEF,
	parameter int SECTORS_PER_PAGE_P = rplm_pkg::SPP_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// sector_address[14:0], entry_index[26:15], target_page[38:27], zero[39]
	input  wire logic [rplm_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  wire logic [rplm_pkg::MODE_W-1:0]     s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// location[12:0], ref_count[25:13], free_page[37:26], found[38], zero[39]
	output logic [rplm_pkg::OUT_DATA_W-1:0]      m_tdata
);

	localparam int MAP_DEPTH = (ENTRIES < rplm_pkg::MAP_LIMIT) ? ENTRIES : rplm_pkg::MAP_LIMIT;
	localparam int PAGES     = (ENTRIES < rplm_pkg::PAGE_SPACE) ? ENTRIES : rplm_pkg::PAGE_SPACE;
	localparam int MW        = $clog2(MAP_DEPTH);
	localparam int PW        = $clog2(PAGES);
	localparam int LW        = rplm_pkg::LOC_W;
	localparam int CNW       = rplm_pkg::CNT_W;
	localparam int PGW       = rplm_pkg::PAGE_W;

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_DIV   = 10'b0000000100,
		ST_RD    = 10'b0000001000,
		ST_EXE   = 10'b0000010000,
		ST_DEC   = 10'b0000100000,
		ST_HCHK  = 10'b0001000000,
		ST_SCAN  = 10'b0010000000,
		ST_NEXT  = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic           found;
		logic [PGW-1:0] page;
		logic [CNW-1:0] cnt;
		logic [LW-1:0]  loc;
	} result_t;

	function automatic logic [CNW-1:0] cnt_inc(input logic [CNW-1:0] c);
		cnt_inc = (c >= rplm_pkg::COUNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic logic [CNW-1:0] cnt_dec(input logic [CNW-1:0] c);
		cnt_dec = (c == '0) ? c : c - 1'b1;
	endfunction

	state_t                 state_q;
	rplm_pkg::mode_t        mode_q;
	logic [rplm_pkg::IDX_W-1:0] idx_q;
	logic [PGW-1:0]         tgt_q;
	logic [MW-1:0]          ent_q;
	logic [MW-1:0]          clr_q;
	logic [LW-1:0]          old_q;
	logic [PGW-1:0]         page_q;
	logic [PGW-1:0]         hint_q;
	logic                   hint_v_q;
	logic [PW:0]            scan_q;
	logic [PW-1:0]          scan_a_s1;
	logic                   scan_v_s1;
	result_t                out_q;

	logic [LW-1:0]          map_mem [MAP_DEPTH];
	logic [CNW-1:0]         cnt_mem [PAGES];
	logic [LW-1:0]          map_rd_q;
	logic [CNW-1:0]         cnt_rd_q;

	logic                   map_we;
	logic [MW-1:0]          map_wa;
	logic [LW-1:0]          map_wd;
	logic [MW-1:0]          map_ra;
	logic                   cnt_we;
	logic [PW-1:0]          cnt_wa;
	logic [CNW-1:0]         cnt_wd;
	logic [PW-1:0]          cnt_ra;

	logic                   in_acc;
	rplm_pkg::mode_t        in_mode;
	logic [rplm_pkg::SECTOR_W-1:0] in_sector;
	logic [rplm_pkg::IDX_W-1:0]    in_idx;
	logic [PGW-1:0]         in_tgt;
	logic                   div_start;
	logic                   div_done;
	logic [rplm_pkg::SECTOR_W-1:0] div_quo;

	logic                   hint_ok;
	logic                   tgt_ok;
	logic                   old_pg;
	logic                   scan_issue;
	logic                   next_ok;

	assign in_acc    = s_tvalid && s_tready;
	assign in_mode   = rplm_pkg::mode_t'(s_tuser);
	assign in_sector = s_tdata[14:0];
	assign in_idx    = s_tdata[26:15];
	assign in_tgt    = s_tdata[38:27];
	assign div_start = in_acc && (in_mode == rplm_pkg::MODE_WRITE);

	assign hint_ok    = hint_v_q && (32'(hint_q) < PAGES);
	assign tgt_ok     = 32'(tgt_q) < PAGES;
	assign old_pg     = 32'(map_rd_q) < PAGES;
	assign scan_issue = 32'(scan_q) < PAGES;
	assign next_ok    = (32'(page_q) + 1) < PAGES;

	rplm_div #(
		.DIVISOR (SECTORS_PER_PAGE_P)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_sector),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rd_q <= map_mem[map_ra];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_q <= cnt_mem[cnt_ra];
	end

	always_comb begin
		map_we = 1'b0;
		map_wa = ent_q;
		map_wd = rplm_pkg::LOC_IN_BUF;
		map_ra = ent_q;
		cnt_we = 1'b0;
		cnt_wa = PW'(tgt_q);
		cnt_wd = cnt_inc(cnt_rd_q);
		cnt_ra = PW'(hint_q);
		case (state_q)
			ST_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				map_wd = rplm_pkg::LOC_UNWRITTEN;
				cnt_we = 32'(clr_q) < PAGES;
				cnt_wa = PW'(clr_q);
				cnt_wd = '0;
			end
			ST_RD: begin
				cnt_ra = (mode_q == rplm_pkg::MODE_FLUSH) ? PW'(tgt_q) : PW'(idx_q);
			end
			ST_EXE: begin
				case (mode_q)
					rplm_pkg::MODE_WRITE: begin
						map_we = 1'b1;
						map_wd = rplm_pkg::LOC_IN_BUF;
						cnt_ra = PW'(map_rd_q);
					end
					rplm_pkg::MODE_FLUSH: begin
						map_we = 1'b1;
						map_wd = LW'(tgt_q);
						cnt_we = tgt_ok;
					end
					default: begin
						map_we = 1'b0;
					end
				endcase
			end
			ST_DEC: begin
				cnt_we = 1'b1;
				cnt_wa = PW'(old_q);
				cnt_wd = cnt_dec(cnt_rd_q);
			end
			ST_HCHK: begin
				cnt_ra = PW'(hint_q + 1'b1);
			end
			ST_SCAN: begin
				cnt_ra = PW'(scan_q);
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			mode_q    <= rplm_pkg::MODE_WRITE;
			idx_q     <= '0;
			tgt_q     <= '0;
			ent_q     <= '0;
			clr_q     <= '0;
			old_q     <= '0;
			page_q    <= '0;
			hint_q    <= '0;
			hint_v_q  <= 1'b1;
			scan_q    <= '0;
			scan_a_s1 <= '0;
			scan_v_s1 <= 1'b0;
			out_q     <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MW'(MAP_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						mode_q <= in_mode;
						idx_q  <= in_idx;
						tgt_q  <= in_tgt;
						ent_q  <= MW'(in_idx);
						case (in_mode)
							rplm_pkg::MODE_WRITE: begin
								state_q <= ST_DIV;
							end
							rplm_pkg::MODE_FLUSH: begin
								if (32'(in_idx) < ENTRIES) begin
									state_q <= ST_RD;
								end else begin
									out_q   <= '{1'b0, '0, '0, rplm_pkg::LOC_UNWRITTEN};
									state_q <= ST_OUT;
								end
							end
							rplm_pkg::MODE_ALLOC: begin
								if (hint_ok) begin
									state_q <= ST_HCHK;
								end else begin
									scan_q    <= '0;
									scan_v_s1 <= 1'b0;
									state_q   <= ST_SCAN;
								end
							end
							default: begin
								state_q <= ST_RD;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (32'(div_quo) < ENTRIES) begin
							ent_q   <= MW'(div_quo);
							state_q <= ST_RD;
						end else begin
							out_q   <= '{1'b0, '0, '0, rplm_pkg::LOC_UNWRITTEN};
							state_q <= ST_OUT;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					case (mode_q)
						rplm_pkg::MODE_WRITE: begin
							old_q <= map_rd_q;
							if (old_pg) begin
								state_q <= ST_DEC;
							end else begin
								out_q   <= '{1'b0, '0, '0, map_rd_q};
								state_q <= ST_OUT;
							end
						end
						rplm_pkg::MODE_FLUSH: begin
							out_q   <= '{1'b0, '0, tgt_ok ? cnt_inc(cnt_rd_q) : '0, map_rd_q};
							state_q <= ST_OUT;
						end
						default: begin
							out_q.found <= 1'b0;
							out_q.page  <= '0;
							out_q.loc   <= (32'(idx_q) < ENTRIES) ? map_rd_q
								: rplm_pkg::LOC_UNWRITTEN;
							out_q.cnt   <= (32'(idx_q) < PAGES) ? cnt_rd_q : '0;
							state_q     <= ST_OUT;
						end
					endcase
				end
				ST_DEC: begin
					out_q   <= '{1'b0, '0, cnt_dec(cnt_rd_q), old_q};
					state_q <= ST_OUT;
				end
				ST_HCHK: begin
					if (cnt_rd_q == '0) begin
						page_q  <= hint_q;
						state_q <= ST_NEXT;
					end else begin
						scan_q    <= '0;
						scan_v_s1 <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_v_s1 <= scan_issue;
					if (scan_issue) begin
						scan_q    <= scan_q + 1'b1;
						scan_a_s1 <= PW'(scan_q);
					end
					if (scan_v_s1 && (cnt_rd_q == '0)) begin
						page_q  <= PGW'(scan_a_s1);
						state_q <= ST_NEXT;
					end else if (!scan_v_s1 && !scan_issue) begin
						hint_v_q <= 1'b0;
						out_q    <= '{1'b0, '0, '0, rplm_pkg::LOC_UNWRITTEN};
						state_q  <= ST_OUT;
					end
				end
				ST_NEXT: begin
					if (next_ok && (cnt_rd_q == '0)) begin
						hint_q   <= page_q + 1'b1;
						hint_v_q <= 1'b1;
					end else begin
						hint_v_q <= 1'b0;
					end
					out_q   <= '{1'b1, page_q, '0, rplm_pkg::LOC_UNWRITTEN};
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {1'b0, out_q};

endmodule

`default_nettype wire

// File: src/rplm_chk.sv
// Port checker for the refcounted page location map, bound to the top level.
// Depends on rplm_pkg and refcounted_page_location_map_top.
`default_nettype none

module rplm_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [rplm_pkg::IN_DATA_W-1:0]  s_tdata,
	input wire logic [rplm_pkg::MODE_W-1:0]     s_tuser,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [rplm_pkg::OUT_DATA_W-1:0] m_tdata
);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after an item was taken");

	a_alloc_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[38] |->
		(m_tdata[12:0] == rplm_pkg::LOC_UNWRITTEN) && (m_tdata[25:13] == '0))
		else $error("allocate result carries a location or count");

	a_no_page_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[38] |-> (m_tdata[37:26] == '0))
		else $error("free page given without found");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind refcounted_page_location_map_top rplm_chk u_rplm_chk (.*);

`default_nettype wire

// File: test/tb_refcounted_page_location_map_top.sv
// Self-checking testbench for refcounted_page_location_map_top: a directed and a random
// mix of sector writes, flush commits, allocates and queries, checked against a shadow model.
// Depends on rplm_pkg and the RTL of the block only.

module tb_refcounted_page_location_map_top;

	localparam int PAGES = (rplm_pkg::ENTRIES_DEF < rplm_pkg::PAGE_SPACE)
		? rplm_pkg::ENTRIES_DEF : rplm_pkg::PAGE_SPACE;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 90;

	typedef struct {
		rplm_pkg::mode_t                 mode;
		logic [rplm_pkg::SECTOR_W-1:0]   sector;
		logic [rplm_pkg::IDX_W-1:0]      entry;
		logic [rplm_pkg::PAGE_W-1:0]     target;
	} page_op_t;

	typedef struct {
		logic [rplm_pkg::LOC_W-1:0]  location;
		logic [rplm_pkg::CNT_W-1:0]  count;
		logic [rplm_pkg::PAGE_W-1:0] page;
		logic                        found;
	} page_outcome_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [rplm_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
	logic [rplm_pkg::MODE_W-1:0]     s_tuser  = rplm_pkg::MODE_QUERY;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [rplm_pkg::OUT_DATA_W-1:0] m_tdata;

	// Shadow copy of the block's tables and allocation hint.
	logic [rplm_pkg::LOC_W-1:0]  shadow_loc [rplm_pkg::ENTRIES_DEF];
	logic [rplm_pkg::CNT_W-1:0]  shadow_refs [rplm_pkg::ENTRIES_DEF];
	logic [rplm_pkg::PAGE_W-1:0] shadow_hint;
	logic                        shadow_hint_ok;

	page_op_t      queued_ops[$];
	page_outcome_t pending_outcomes[$];

	page_op_t      offered;
	page_outcome_t outcome;
	page_outcome_t want;
	int burst_left = 0;
	int gap_left = 0;
	int seg_left = 0;
	int seg_kind = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int idle_cycles = 0;
	int fails = 0;
	int results_checked = 0;
	int mode_tally [4] = '{0, 0, 0, 0};
	int alloc_misses = 0;

	refcounted_page_location_map_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic location_page_ok(input logic [rplm_pkg::LOC_W-1:0] loc);
		return (!loc[rplm_pkg::LOC_W-1] && int'(loc) < PAGES);
	endfunction

	function automatic void move_hint_past(input int p);
		if (p + 1 < PAGES && shadow_refs[p + 1] == '0) begin
			shadow_hint    = rplm_pkg::PAGE_W'(p + 1);
			shadow_hint_ok = 1'b1;
		end else begin
			shadow_hint_ok = 1'b0;
		end
	endfunction

	function automatic page_outcome_t predict_outcome(input page_op_t op);
		page_outcome_t r;
		int e;
		int p;
		int hit;
		logic [rplm_pkg::LOC_W-1:0] old;
		r = '{location: rplm_pkg::LOC_UNWRITTEN, count: '0, page: '0, found: 1'b0};
		case (op.mode)
			rplm_pkg::MODE_WRITE: begin
				e = int'(op.sector) / rplm_pkg::SPP_DEF;
				if (e < rplm_pkg::ENTRIES_DEF) begin
					old = shadow_loc[e];
					if (location_page_ok(old)) begin
						if (shadow_refs[old] != '0)
							shadow_refs[old] = shadow_refs[old] - 1'b1;
						r.count = shadow_refs[old];
					end
					shadow_loc[e] = rplm_pkg::LOC_IN_BUF;
					r.location = old;
				end
			end
			rplm_pkg::MODE_FLUSH: begin
				e = int'(op.entry);
				if (e < rplm_pkg::ENTRIES_DEF) begin
					r.location = shadow_loc[e];
					shadow_loc[e] = {1'b0, op.target};
					if (int'(op.target) < PAGES) begin
						if (shadow_refs[op.target] < rplm_pkg::COUNT_MAX)
							shadow_refs[op.target] = shadow_refs[op.target] + 1'b1;
						r.count = shadow_refs[op.target];
					end
				end
			end
			rplm_pkg::MODE_ALLOC: begin
				hit = -1;
				if (shadow_hint_ok && int'(shadow_hint) < PAGES
						&& shadow_refs[shadow_hint] == '0)
					hit = int'(shadow_hint);
				else begin
					for (p = 0; p < PAGES && hit < 0; p++)
						if (shadow_refs[p] == '0)
							hit = p;
				end
				if (hit >= 0) begin
					move_hint_past(hit);
					r.page  = rplm_pkg::PAGE_W'(hit);
					r.found = 1'b1;
				end else begin
					shadow_hint_ok = 1'b0;
				end
			end
			default: begin
				if (int'(op.entry) < rplm_pkg::ENTRIES_DEF)
					r.location = shadow_loc[op.entry];
				if (int'(op.entry) < PAGES)
					r.count = shadow_refs[op.entry];
			end
		endcase
		return r;
	endfunction

	task automatic queue_op(input rplm_pkg::mode_t m, input int unsigned sector,
			input int unsigned entry, input int unsigned target);
		page_op_t op;
		op.mode   = m;
		op.sector = rplm_pkg::SECTOR_W'(sector);
		op.entry  = rplm_pkg::IDX_W'(entry);
		op.target = rplm_pkg::PAGE_W'(target);
		queued_ops.push_back(op);
	endtask

	// Driver: bursts of items with random gaps; a held item stays on the bus until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= rplm_pkg::MODE_QUERY;
			burst_left = 0;
			gap_left = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				outcome = predict_outcome(offered);
				pending_outcomes.push_back(outcome);
				mode_tally[offered.mode]++;
				if (offered.mode == rplm_pkg::MODE_ALLOC && !outcome.found)
					alloc_misses++;
			end
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (queued_ops.size() > 0) begin
				offered = queued_ops.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {1'b0, offered.target, offered.entry, offered.sector};
				s_tuser <= offered.mode;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result item and drives its own stall pattern on tready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_outcomes.size() == 0) begin
					$error("result item with no expectation waiting: tdata %h", m_tdata);
					fails++;
				end else begin
					want = pending_outcomes.pop_front();
					results_checked++;
					if (m_tdata[12:0] !== want.location) begin
						$error("location: expected %0d, actual %0d",
							$signed(want.location), $signed(m_tdata[12:0]));
						fails++;
					end
					if (m_tdata[25:13] !== want.count) begin
						$error("ref_count: expected %0d, actual %0d", want.count, m_tdata[25:13]);
						fails++;
					end
					if (m_tdata[37:26] !== want.page) begin
						$error("free_page: expected %0d, actual %0d", want.page, m_tdata[37:26]);
						fails++;
					end
					if (m_tdata[38] !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, m_tdata[38]);
						fails++;
					end
				end
			end
			if (!hold_done && results_checked == 30) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (seg_left == 0) begin
				seg_kind = $urandom_range(0, 3);
				seg_left = $urandom_range(5, 60);
			end else begin
				seg_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (seg_kind)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= seg_left[0];
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout after %0d cycles with no item moving", idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int n;
		int e;
		for (i = 0; i < rplm_pkg::ENTRIES_DEF; i++) begin
			shadow_loc[i] = rplm_pkg::LOC_UNWRITTEN;
			shadow_refs[i] = '0;
		end
		shadow_hint = '0;
		shadow_hint_ok = 1'b1;

		// Directed part: empty table, hint use, stale hint, buffer marking, field extremes.
		queue_op(rplm_pkg::MODE_QUERY, 0, 0, 0);
		queue_op(rplm_pkg::MODE_QUERY, 32767, 4095, 4095);
		queue_op(rplm_pkg::MODE_ALLOC, 0, 0, 0);
		queue_op(rplm_pkg::MODE_FLUSH, 0, 0, 0);
		queue_op(rplm_pkg::MODE_ALLOC, 0, 0, 0);
		queue_op(rplm_pkg::MODE_FLUSH, 0, 1, 2);
		queue_op(rplm_pkg::MODE_ALLOC, 0, 0, 0);
		queue_op(rplm_pkg::MODE_ALLOC, 32767, 4095, 4095);
		queue_op(rplm_pkg::MODE_FLUSH, 32767, 4095, 4095);
		queue_op(rplm_pkg::MODE_FLUSH, 0, 4094, 4095);
		queue_op(rplm_pkg::MODE_QUERY, 0, 4095, 0);
		queue_op(rplm_pkg::MODE_WRITE, 32767, 0, 0);
		queue_op(rplm_pkg::MODE_WRITE, 32760, 4095, 4095);
		queue_op(rplm_pkg::MODE_QUERY, 0, 4095, 0);
		queue_op(rplm_pkg::MODE_WRITE, 0, 4095, 4095);
		queue_op(rplm_pkg::MODE_FLUSH, 32767, 0, 0);
		queue_op(rplm_pkg::MODE_FLUSH, 32767, 5, 5);
		queue_op(rplm_pkg::MODE_WRITE, 47, 4095, 4095);
		queue_op(rplm_pkg::MODE_QUERY, 32767, 5, 4095);
		queue_op(rplm_pkg::MODE_ALLOC, 32767, 4095, 4095);
		queue_op(rplm_pkg::MODE_QUERY, 0, 1, 0);

		// Random part: mostly allocate, commit, query and overwrite runs on a few pages.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 6) begin
				e = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 63);
				queue_op(rplm_pkg::MODE_ALLOC, $urandom, $urandom, $urandom);
				queue_op(rplm_pkg::MODE_FLUSH, $urandom, e,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 31));
				n += 3;
				if ($urandom_range(0, 1)) begin
					queue_op(rplm_pkg::MODE_QUERY, $urandom, e, $urandom);
					n++;
				end
				queue_op(rplm_pkg::MODE_WRITE,
					e * rplm_pkg::SPP_DEF + $urandom_range(0, rplm_pkg::SPP_DEF - 1),
					$urandom, $urandom);
			end else begin
				queue_op(rplm_pkg::mode_t'($urandom_range(0, 3)), $urandom_range(0, 32767),
					($urandom_range(0, 1)) ? $urandom_range(0, 4095) : $urandom_range(0, 63),
					($urandom_range(0, 1)) ? $urandom_range(0, 4095) : $urandom_range(0, 31));
				n++;
			end
		end

		for (i = 0; i < 30; i++)
			queue_op(($urandom_range(0, 5) == 0) ? rplm_pkg::MODE_ALLOC
					: rplm_pkg::mode_t'($urandom_range(0, 1) * 3),
				$urandom_range(0, 32767), $urandom_range(0, 4095), $urandom_range(0, 4095));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (queued_ops.size() != 0 || s_tvalid || pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Checked %0d results: %0d sector writes, %0d flush commits, %0d queries,",
			results_checked, mode_tally[rplm_pkg::MODE_WRITE],
			mode_tally[rplm_pkg::MODE_FLUSH], mode_tally[rplm_pkg::MODE_QUERY]);
		$display("and %0d allocates, %0d of them with no free page left.",
			mode_tally[rplm_pkg::MODE_ALLOC], alloc_misses);
		if (fails == 0 && pending_outcomes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
